/* hw/rtl/sha1_message_digest_core_defines.svh */
// Assertion macros shared by the SHA-1 digest core RTL.
`ifndef SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHA1MD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHA1MD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sha1md_pkg.sv */
// Types and constants of the SHA-1 digest core.
`timescale 1ns / 1ps

package sha1md_pkg;

    // Initial chaining values h0..h4
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per 20-round phase
    localparam logic [31:0] K_PH0 = 32'h5A827999;
    localparam logic [31:0] K_PH1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_PH2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_PH3 = 32'hCA62C1D6;

    // Round numbering
    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [6:0] ROUNDS       = 7'd80;
    localparam logic [6:0] EXPAND_START = 7'd16;
    localparam logic [6:0] PH1_START    = 7'd20;
    localparam logic [6:0] PH2_START    = 7'd40;
    localparam logic [6:0] PH3_START    = 7'd60;

    // Block byte positions
    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [5:0] PRE_LEN_POS = 6'd55;

    // Padding marker byte
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Index of the final digest word
    localparam logic [2:0] LAST_IDX = 3'd4;

    // Control of the message schedule window
    typedef struct packed {
        logic       load;    // shift one byte in
        logic       step;    // advance one round
        logic       expand;  // round uses expanded word
        logic [7:0] data;    // byte to shift in
    } sched_ctrl_t;

endpackage

/* hw/rtl/sha1md_sched.sv */
// Message block window: byte loader and SHA-1 word schedule.
`timescale 1ns / 1ps

module sha1md_sched
(
    input  logic                    clk,
    input  sha1md_pkg::sched_ctrl_t ctrl,
    output logic [31:0]             w
);

    // 16 words, oldest word in the top bits
    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [31:0]  mix;

    // Schedule recurrence from fixed taps of the window
    always_comb
    begin
        mix = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ win_reg[511:480];
        if (ctrl.expand)
        begin
            w = {mix[30:0], mix[31]};
        end
        else
        begin
            w = win_reg[511:480];
        end
    end

    // Byte shift for loading, word shift for rounds
    always_comb
    begin
        win_next = win_reg;
        if (ctrl.load)
        begin
            win_next = {win_reg[503:0], ctrl.data};
        end
        else if (ctrl.step)
        begin
            win_next = {win_reg[479:0], w};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

/* hw/rtl/sha1md_round.sv */
// One SHA-1 round: shared datapath used once per cycle by the sequencer.
`timescale 1ns / 1ps

module sha1md_round
(
    input  logic [6:0]  round,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] e,
    input  logic [31:0] w,
    output logic [31:0] t
);

    logic [31:0] f;
    logic [31:0] k;

    // Boolean function and constant by phase
    always_comb
    begin
        if (round < sha1md_pkg::PH1_START)
        begin
            f = (b & c) | (~b & d);
            k = sha1md_pkg::K_PH0;
        end
        else if (round < sha1md_pkg::PH2_START)
        begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_PH1;
        end
        else if (round < sha1md_pkg::PH3_START)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1md_pkg::K_PH2;
        end
        else
        begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_PH3;
        end
    end

    // New a
    assign t = {a[26:0], a[31:27]} + f + e + w + k;

endmodule

/* hw/rtl/sha1_message_digest_core.sv */
// Top level of the SHA-1 digest core: sequencer, hash state and output.
//
// Input stream: s_tdata holds a message byte, s_tuser[0] says the byte is
// valid, s_tlast ends the message (with or without a byte). Output stream:
// five beats per message, h0 first, m_tuser giving the word index and
// m_tlast set on h4.
// Timing: s_tready is high only while the core idles. A beat that fills the
// 64-byte block starts a compression: 80 rounds on the single shared round
// unit, then the chaining add. After the ending beat the core shifts padding
// and length in at one byte per cycle, pausing for a compression whenever
// the block fills, runs one or two compressions, then presents the digest.
// Reset clears the sequencer and loads the initial hash; no clearing pass.
// While the receiver stalls, the current digest beat holds and no input
// is taken; after the h4 beat the hash and bit count return to reset values.
`timescale 1ns / 1ps
`include "sha1_message_digest_core_defines.svh"

module sha1_message_digest_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_msg
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_LEN, S_ROUND, S_ADD, S_OUT} state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pad_active_reg, pad_active_next;
    logic        pad_first_reg, pad_first_next;
    logic        final_reg, final_next;
    logic [31:0] hash_reg [5];
    logic [31:0] hash_next [5];
    logic [31:0] work_reg [5];

    logic                    launch;
    logic [5:0]              len_sel;
    logic [31:0]             sched_w;
    logic [31:0]             round_t;
    sha1md_pkg::sched_ctrl_t sched_ctrl;

    // Length bytes go out most significant first
    assign len_sel = {~pos_reg[2:0], 3'b000};

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        bit_len_next    = bit_len_reg;
        round_next      = round_reg;
        out_idx_next    = out_idx_reg;
        pad_active_next = pad_active_reg;
        pad_first_next  = pad_first_reg;
        final_next      = final_reg;
        hash_next       = hash_reg;
        sched_ctrl      = '0;
        launch          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                    begin
                        sched_ctrl.load = 1'b1;
                        sched_ctrl.data = s_tdata;
                        bit_len_next    = bit_len_reg + 64'd8;
                        pos_next        = pos_reg + 6'd1;
                    end
                    if (s_tlast)
                    begin
                        pad_active_next = 1'b1;
                        pad_first_next  = 1'b1;
                    end
                    if (s_tuser[0] && pos_reg == sha1md_pkg::LAST_POS)
                    begin
                        launch = 1'b1;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                sched_ctrl.load = 1'b1;
                sched_ctrl.data = pad_first_reg ? sha1md_pkg::PAD_BYTE
                                                : sha1md_pkg::ZERO_BYTE;
                pad_first_next  = 1'b0;
                pos_next        = pos_reg + 6'd1;
                if (pos_reg == sha1md_pkg::LAST_POS)
                begin
                    launch = 1'b1;
                end
                else if (pos_reg == sha1md_pkg::PRE_LEN_POS)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                sched_ctrl.load = 1'b1;
                sched_ctrl.data = bit_len_reg[len_sel +: 8];
                pos_next        = pos_reg + 6'd1;
                if (pos_reg == sha1md_pkg::LAST_POS)
                begin
                    launch     = 1'b1;
                    final_next = 1'b1;
                end
            end
            S_ROUND:
            begin
                sched_ctrl.step   = 1'b1;
                sched_ctrl.expand = (round_reg >= sha1md_pkg::EXPAND_START);
                round_next        = round_reg + 7'd1;
                if (round_reg == sha1md_pkg::LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                if (final_reg)
                begin
                    state_next   = S_OUT;
                    out_idx_next = 3'd0;
                end
                else if (pad_active_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == sha1md_pkg::LAST_IDX)
                    begin
                        state_next      = S_IDLE;
                        hash_next       = sha1md_pkg::H_INIT;
                        bit_len_next    = 64'd0;
                        pad_active_next = 1'b0;
                        final_next      = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (launch)
        begin
            state_next = S_ROUND;
            round_next = 7'd0;
        end
    end

    // State and registered control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= 6'd0;
            bit_len_reg    <= 64'd0;
            round_reg      <= 7'd0;
            out_idx_reg    <= 3'd0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            final_reg      <= 1'b0;
            hash_reg       <= sha1md_pkg::H_INIT;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            bit_len_reg    <= bit_len_next;
            round_reg      <= round_next;
            out_idx_reg    <= out_idx_next;
            pad_active_reg <= pad_active_next;
            pad_first_reg  <= pad_first_next;
            final_reg      <= final_next;
            hash_reg       <= hash_next;
        end
    end

    // Working variables a..e
    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            work_reg <= hash_reg;
        end
        else if (state_reg == S_ROUND)
        begin
            work_reg[0] <= round_t;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

    sha1md_sched u_sched
    (
        .clk  (clk),
        .ctrl (sched_ctrl),
        .w    (sched_w)
    );

    sha1md_round u_round
    (
        .round (round_reg),
        .a     (work_reg[0]),
        .b     (work_reg[1]),
        .c     (work_reg[2]),
        .d     (work_reg[3]),
        .e     (work_reg[4]),
        .w     (sched_w),
        .t     (round_t)
    );

    // Stream outputs
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = hash_reg[out_idx_reg];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == sha1md_pkg::LAST_IDX);

    // Checks
    `SHA1MD_ASSERT_IMP(a_no_overlap, s_tready, !m_tvalid, "input taken during digest output")
    `SHA1MD_ASSERT_IMP(a_round_bound, state_reg == S_ROUND, round_reg < sha1md_pkg::ROUNDS,
        "round counter past last round")
    `SHA1MD_ASSERT_NXT(a_round_done, state_reg == S_ROUND && round_reg == sha1md_pkg::LAST_ROUND,
        state_reg == S_ADD, "compression did not end in chaining add")
    `SHA1MD_ASSERT_NXT(a_digest_reset, m_tvalid && m_tready && m_tlast,
        bit_len_reg == 64'd0 && pos_reg == 6'd0 && hash_reg[0] == sha1md_pkg::H_INIT[0],
        "state not reset after digest")

endmodule
